/* rtl/array_bst_insert_search_core_defines.svh */
// Assertion macros for the array BST insert/search core.
`ifndef ARRAY_BST_INSERT_SEARCH_CORE_DEFINES_SVH
`define ARRAY_BST_INSERT_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ABST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ABST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/abst_pkg.sv */
// Shared types and constants for the array BST insert/search core.
`timescale 1ns / 1ps
`default_nettype none
package abst_pkg;

    localparam int KEY_W    = 32;
    localparam int ENTRY_W  = KEY_W + 1;   // valid flag over the stored key
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic                    command;
        logic signed [KEY_W-1:0] key_value;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_index;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
    } out_item_t;

    typedef struct packed {
        logic eq;   // key equals node
        logic gt;   // key greater than node, signed
    } cmp_t;

endpackage
`default_nettype wire

/* rtl/abst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module abst_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

/* rtl/abst_cmp.sv */
// Shared key compare unit: equality and signed greater-than.
`timescale 1ns / 1ps
`default_nettype none
module abst_cmp (
    input  wire logic signed [abst_pkg::KEY_W-1:0] key_value,
    input  wire logic        [abst_pkg::KEY_W-1:0] node_value,
    output abst_pkg::cmp_t                         result
);
    import abst_pkg::*;

    assign result.eq = (key_value == $signed(node_value));
    assign result.gt = (key_value >  $signed(node_value));

endmodule
`default_nettype wire

/* rtl/array_bst_insert_search_core.sv */
// Top level: array-embedded binary search tree with insert and search commands.
//
//  Channel  | Ports                         | Handshake
//  ---------+-------------------------------+-----------------------------------
//  command  | start, busy, item             | beat taken when start && !busy
//  result   | result_valid, result          | one-cycle strobe, cannot be held
//
// One beat walks the tree one level per cycle: the registered RAM read of the
// current slot feeds the shared compare unit, whose outcome picks the child
// address for the next read. An item visits at most ceil(log2(SLOT_COUNT+1))
// levels, 11 for 1024 slots; the result strobe follows in the cycle after the
// last level, busy low.
// After reset the slot store is swept clear, one slot per cycle, with busy
// high. The result side never stalls.
`timescale 1ns / 1ps
`include "array_bst_insert_search_core_defines.svh"
`default_nettype none
module array_bst_insert_search_core #(
    parameter int SLOT_COUNT = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire abst_pkg::in_item_t  item,
    output logic                     result_valid,
    output abst_pkg::out_item_t      result
);
    import abst_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);   // slot address
    localparam int CW = AW + 2;               // child index, reaches 2*SLOT_COUNT

    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOT_COUNT - 1);

    // sequencer states
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic                cmd_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                result_valid_reg, result_valid_next;
    out_item_t           result_reg, result_next;

    logic                accept;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic [AW-1:0]       rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    logic                node_valid;
    logic [KEY_W-1:0]    node_value;
    cmp_t                cmp;
    logic [CW-1:0]       child;
    logic                child_in;

    assign accept     = start && (state_reg == S_IDLE);
    assign node_valid = rd_data[KEY_W];
    assign node_value = rd_data[KEY_W-1:0];

    // slot store: valid flag plus key per slot
    abst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    abst_cmp u_cmp (
        .key_value  (key_reg),
        .node_value (node_value),
        .result     (cmp)
    );

    // right child 2i+2 when key is greater, else left child 2i+1
    assign child    = {1'b0, pos_reg, 1'b0} + (cmp.gt ? CW'(2) : CW'(1));
    assign child_in = (child < CW'(SLOT_COUNT));

    // read address for the next cycle: root on accept, child while walking
    assign rd_addr = (state_reg == S_LOOK) ? child[AW-1:0] : '0;

    always_comb
    begin
        state_next        = state_reg;
        pos_next          = pos_reg;
        clr_next          = clr_reg;
        count_next        = count_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        wr_en             = 1'b0;
        wr_addr           = pos_reg;
        wr_data           = {1'b1, key_reg};

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    pos_next   = '0;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                result_next.slot_index  = '0;
                result_next.entry_count = count_reg;
                if (!node_valid)
                begin
                    // empty slot ends the walk for either command
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                    if (cmd_reg == CMD_INSERT)
                    begin
                        wr_en = 1'b1;
                        if (count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        result_next.entry_count = count_next;
                        result_next.slot_index  = SLOT_W'(pos_reg);
                        result_next.status      = ST_OK;
                    end
                    else
                    begin
                        result_next.status = ST_NOT_FOUND;
                    end
                end
                else if ((cmd_reg == CMD_SEARCH) && cmp.eq)
                begin
                    result_valid_next      = 1'b1;
                    state_next             = S_IDLE;
                    result_next.slot_index = SLOT_W'(pos_reg);
                    result_next.status     = ST_OK;
                end
                else if (!child_in)
                begin
                    // walk would leave the array
                    result_valid_next  = 1'b1;
                    state_next         = S_IDLE;
                    result_next.status = ST_FULL;
                end
                else
                begin
                    pos_next = child[AW-1:0];
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            pos_reg          <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            pos_reg          <= pos_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            cmd_reg <= item.command;
            key_reg <= item.key_value;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ABST_ASSERT_NEXT(a_single_strobe, result_valid_reg, !result_valid_reg,
        "result strobe lasted more than one cycle")
    `ABST_ASSERT_NEXT(a_walk_from_root, accept, (state_reg == S_LOOK) && (pos_reg == '0),
        "accepted beat did not start its walk at the root slot")
    `ABST_ASSERT_NOW(a_slot_zero_on_miss,
        result_valid_reg && (result_reg.status != ST_OK), result_reg.slot_index == '0,
        "nonzero slot reported with a miss or full status")
    `ABST_ASSERT_NOW(a_no_strobe_while_busy, result_valid_reg, !busy,
        "result strobe raised while still walking or clearing")

endmodule
`default_nettype wire
